[hw/rtl/skq_pkg.sv]
// skq_pkg: shared types, codes and ascii tables for the scancode key queue
// no dependencies; compiled first
`default_nettype none

package skq_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int KEYCODE_W       = 10;
	localparam int ASCII_W         = 8;

	// set-1 scancodes of the modifier keys (release bit stripped)
	localparam logic [6:0] CODE_CTRL   = 7'h1d;
	localparam logic [6:0] CODE_ALT    = 7'h38;
	localparam logic [6:0] CODE_LSHIFT = 7'h2a;
	localparam logic [6:0] CODE_RSHIFT = 7'h36;
	localparam logic [6:0] CODE_CAPS   = 7'h3a;
	// first make code past the character tables
	localparam logic [6:0] TABLE_LEN   = 7'h3a;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_KEY   = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_PUSH = 2'd1,
		OP_POP  = 2'd2
	} op_kind_t;

	// classified work handed from the front to the back
	typedef struct packed {
		op_kind_t               kind;
		logic [KEYCODE_W-1:0]   word;
	} op_t;

	// unshifted character for a make code below TABLE_LEN, zero for holes
	function automatic logic [ASCII_W-1:0] plain_ascii(input logic [5:0] key);
		logic [ASCII_W-1:0] c;
		case (key)
			6'h01: c = 8'h1b;
			6'h02: c = "1";
			6'h03: c = "2";
			6'h04: c = "3";
			6'h05: c = "4";
			6'h06: c = "5";
			6'h07: c = "6";
			6'h08: c = "7";
			6'h09: c = "8";
			6'h0a: c = "9";
			6'h0b: c = "0";
			6'h0c: c = "-";
			6'h0d: c = "=";
			6'h0e: c = 8'h08;
			6'h0f: c = 8'h09;
			6'h10: c = "q";
			6'h11: c = "w";
			6'h12: c = "e";
			6'h13: c = "r";
			6'h14: c = "t";
			6'h15: c = "y";
			6'h16: c = "u";
			6'h17: c = "i";
			6'h18: c = "o";
			6'h19: c = "p";
			6'h1a: c = "[";
			6'h1b: c = "]";
			6'h1c: c = 8'h0a;
			6'h1e: c = "a";
			6'h1f: c = "s";
			6'h20: c = "d";
			6'h21: c = "f";
			6'h22: c = "g";
			6'h23: c = "h";
			6'h24: c = "j";
			6'h25: c = "k";
			6'h26: c = "l";
			6'h27: c = ";";
			6'h28: c = 8'h27;
			6'h29: c = 8'h60;
			6'h2b: c = 8'h5c;
			6'h2c: c = "z";
			6'h2d: c = "x";
			6'h2e: c = "c";
			6'h2f: c = "v";
			6'h30: c = "b";
			6'h31: c = "n";
			6'h32: c = "m";
			6'h33: c = ",";
			6'h34: c = ".";
			6'h35: c = "/";
			6'h39: c = 8'h20;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// shifted character for a make code below TABLE_LEN, zero for holes
	function automatic logic [ASCII_W-1:0] shift_ascii(input logic [5:0] key);
		logic [ASCII_W-1:0] c;
		case (key)
			6'h01: c = 8'h1b;
			6'h02: c = "!";
			6'h03: c = "@";
			6'h04: c = "#";
			6'h05: c = "$";
			6'h06: c = "%";
			6'h07: c = "^";
			6'h08: c = "&";
			6'h09: c = "*";
			6'h0a: c = "(";
			6'h0b: c = ")";
			6'h0c: c = "_";
			6'h0d: c = "+";
			6'h0e: c = 8'h08;
			6'h0f: c = 8'h09;
			6'h10: c = "Q";
			6'h11: c = "W";
			6'h12: c = "E";
			6'h13: c = "R";
			6'h14: c = "T";
			6'h15: c = "Y";
			6'h16: c = "U";
			6'h17: c = "I";
			6'h18: c = "O";
			6'h19: c = "P";
			6'h1a: c = "{";
			6'h1b: c = "}";
			6'h1c: c = 8'h0a;
			6'h1e: c = "A";
			6'h1f: c = "S";
			6'h20: c = "D";
			6'h21: c = "F";
			6'h22: c = "G";
			6'h23: c = "H";
			6'h24: c = "J";
			6'h25: c = "K";
			6'h26: c = "L";
			6'h27: c = ":";
			6'h28: c = 8'h22;
			6'h29: c = "~";
			6'h2b: c = "|";
			6'h2c: c = "Z";
			6'h2d: c = "X";
			6'h2e: c = "C";
			6'h2f: c = "V";
			6'h30: c = "B";
			6'h31: c = "N";
			6'h32: c = "M";
			6'h33: c = "<";
			6'h34: c = ">";
			6'h35: c = "?";
			6'h39: c = 8'h20;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/skq_in_if.sv]
// skq_in_if: input channel carrying scancodes and read requests
// depends on nothing
`default_nettype none

interface skq_in_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] scan_byte;

	modport source (output valid, output func, output scan_byte, input ready);
	modport sink   (input valid, input func, input scan_byte, output ready);
endinterface

`default_nettype wire

[hw/rtl/skq_out_if.sv]
// skq_out_if: result channel carrying status and keycode
// depends on nothing
`default_nettype none

interface skq_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [9:0] keycode;

	modport source (output valid, output status, output keycode, input ready);
	modport sink   (input valid, input status, input keycode, output ready);
endinterface

`default_nettype wire

[hw/rtl/skq_front.sv]
// skq_front: takes input transfers, tracks held modifiers, looks up ascii
// depends on skq_pkg and skq_in_if
`default_nettype none

module skq_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	skq_in_if.sink             key_in,
	output skq_pkg::op_t       op,
	output logic               op_valid,
	input  wire logic          op_ready
);
	import skq_pkg::*;

	logic                 lshift_q;
	logic                 rshift_q;
	logic                 caps_q;
	logic                 ctrl_q;
	logic                 alt_q;
	logic                 accept;
	logic                 pressed;
	logic [6:0]           key;
	logic                 is_mod;
	logic [ASCII_W-1:0]   ascii;

	assign key_in.ready = op_ready;
	assign op_valid     = key_in.valid;
	assign accept       = key_in.valid && op_ready;
	assign pressed      = !key_in.scan_byte[7];
	assign key          = key_in.scan_byte[6:0];

	// modifier keys never produce a character
	always_comb begin
		case (key)
			CODE_CTRL, CODE_ALT, CODE_LSHIFT, CODE_RSHIFT, CODE_CAPS: is_mod = 1'b1;
			default: is_mod = 1'b0;
		endcase
	end

	// character lookup, shifted while any shift or capslock is held
	always_comb begin
		if (lshift_q || rshift_q || caps_q) begin
			ascii = shift_ascii(key[5:0]);
		end else begin
			ascii = plain_ascii(key[5:0]);
		end
	end

	// classify the item into an op for the back
	always_comb begin
		op.kind = OP_NONE;
		op.word = {ctrl_q, alt_q, ascii};
		if (key_in.func) begin
			op.kind = OP_POP;
		end else if (!is_mod && pressed && key < TABLE_LEN && ascii != '0) begin
			op.kind = OP_PUSH;
		end
	end

	// held-modifier flags follow make and break codes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lshift_q <= 1'b0;
			rshift_q <= 1'b0;
			caps_q   <= 1'b0;
			ctrl_q   <= 1'b0;
			alt_q    <= 1'b0;
		end else if (accept && !key_in.func) begin
			case (key)
				CODE_CTRL:   ctrl_q   <= pressed;
				CODE_ALT:    alt_q    <= pressed;
				CODE_LSHIFT: lshift_q <= pressed;
				CODE_RSHIFT: rshift_q <= pressed;
				CODE_CAPS:   caps_q   <= pressed;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

[hw/rtl/skq_opq.sv]
// skq_opq: two-entry queue of classified ops between front and back
// depends on skq_pkg
`default_nettype none

module skq_opq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire skq_pkg::op_t  wr_op,
	input  wire logic          wr_valid,
	output logic               wr_ready,
	output skq_pkg::op_t       rd_op,
	output logic               rd_valid,
	input  wire logic          rd_ready
);
	import skq_pkg::*;

	op_t        slot_q [2];
	logic       wr_idx_q;
	logic       rd_idx_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign wr_ready = count_q != 2'd2;
	assign rd_valid = count_q != 2'd0;
	assign rd_op    = slot_q[rd_idx_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_idx_q] <= wr_op;
		end
	end

	// indexes and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q <= 1'b0;
			rd_idx_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_idx_q <= !wr_idx_q;
			end
			if (pop) begin
				rd_idx_q <= !rd_idx_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/skq_back.sv]
// skq_back: keycode ring store, pointers and the result register
// depends on skq_pkg and skq_out_if
`default_nettype none

module skq_back #(
	parameter int QUEUE_DEPTH = skq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire skq_pkg::op_t  op,
	input  wire logic          op_valid,
	output logic               op_ready,
	skq_out_if.source          key_out
);
	import skq_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	logic [KEYCODE_W-1:0] store_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]     wr_ptr_q;
	logic [PTR_W-1:0]     rd_ptr_q;
	logic [PTR_W-1:0]     wr_next;
	logic [PTR_W-1:0]     rd_next;
	logic                 out_valid_q;
	status_t              status_q;
	logic [KEYCODE_W-1:0] rdata_q;
	logic                 take;
	logic                 is_full;
	logic                 is_empty;
	logic                 do_push;
	logic                 do_pop;
	status_t              status_d;

	assign wr_next  = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
	assign rd_next  = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
	assign is_full  = wr_next == rd_ptr_q;
	assign is_empty = wr_ptr_q == rd_ptr_q;

	// take an op whenever the result register is free or being drained
	assign op_ready = !out_valid_q || key_out.ready;
	assign take     = op_valid && op_ready;
	assign do_push  = take && op.kind == OP_PUSH && !is_full;
	assign do_pop   = take && op.kind == OP_POP && !is_empty;

	// status of the op being taken
	always_comb begin
		case (op.kind)
			OP_PUSH: status_d = is_full ? ST_FULL : ST_DONE;
			OP_POP:  status_d = is_empty ? ST_EMPTY : ST_KEY;
			default: status_d = ST_DONE;
		endcase
	end

	// keycode store, written at the write pointer, read data registered
	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= op.word;
		end
		if (do_pop) begin
			rdata_q <= store_q[rd_ptr_q];
		end
	end

	// pointers and result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ST_DONE;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_next;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_next;
			end
			if (take) begin
				out_valid_q <= 1'b1;
				status_q    <= status_d;
			end else if (key_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign key_out.valid   = out_valid_q;
	assign key_out.status  = status_q;
	assign key_out.keycode = (status_q == ST_KEY) ? rdata_q : '0;

	// pointers stay inside the ring
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q <= PTR_LAST) && (rd_ptr_q <= PTR_LAST))
		else $error("ring pointer out of range");

	// a read of an empty ring leaves the read pointer alone
	a_empty_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(take && op.kind == OP_POP && is_empty) |=> (rd_ptr_q == $past(rd_ptr_q)))
		else $error("read pointer moved on empty read");

	// a dropped push leaves the write pointer alone
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(take && op.kind == OP_PUSH && is_full) |=> (wr_ptr_q == $past(wr_ptr_q)))
		else $error("write pointer moved on dropped push");

	// a taken op always shows up as a result on the next cycle
	a_take_result: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> out_valid_q)
		else $error("taken op produced no result");

endmodule

`default_nettype wire

[hw/rtl/scancode_to_ascii_key_queue_top.sv]
// scancode_to_ascii_key_queue_top: scancode to ascii keycode queue
// depends on skq_pkg, skq_in_if, skq_out_if, skq_front, skq_opq, skq_back
//
//   channel   dir   payload                        handshake
//   key_in    in    func, scan_byte[7:0]           valid / ready
//   key_out   out   status[1:0], keycode[9:0]      valid / ready
//
// one item per cycle sustained while key_out takes results; a result follows its transfer
// (front classifies into the op queue, back updates the ring and result register)
// the two-entry op queue lets the front take up to two items while key_out stalls
// reset clears modifier flags, ring pointers and queue counts; no clearing pass
// the keycode ring holds QUEUE_DEPTH-1 entries; pushes into a full ring are dropped
`default_nettype none

module scancode_to_ascii_key_queue_top #(
	parameter int QUEUE_DEPTH = skq_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	skq_in_if.sink     key_in,
	skq_out_if.source  key_out
);
	import skq_pkg::*;

	op_t  front_op;
	logic front_valid;
	logic front_ready;
	op_t  back_op;
	logic back_valid;
	logic back_ready;

	// classify incoming transfers
	skq_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.key_in   (key_in),
		.op       (front_op),
		.op_valid (front_valid),
		.op_ready (front_ready)
	);

	// decoupling queue
	skq_opq u_opq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_op    (front_op),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.rd_op    (back_op),
		.rd_valid (back_valid),
		.rd_ready (back_ready)
	);

	// ring store and results
	skq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (back_op),
		.op_valid (back_valid),
		.op_ready (back_ready),
		.key_out  (key_out)
	);

endmodule

`default_nettype wire
